@@ rtl/core/lldedup_pkg.sv @@
// Shared constants, codes and types of the linked list deduplication core.
package lldedup_pkg;

  // Node table and key bitmap sizes; both are powers of two.
  localparam int NODE_COUNT = 65536;
  localparam int KEY_RANGE  = 32768;
  localparam int NODE_AW    = $clog2(NODE_COUNT);
  localparam int KEY_AW     = $clog2(KEY_RANGE);

  // Field widths.
  localparam int ADDR_W  = 16;
  localparam int VALUE_W = 16;
  localparam int NEXT_W  = 17;
  localparam int OP_W    = 2;

  // Stream data widths, rounded up to whole bytes.
  localparam int FIELDS_W = ADDR_W + VALUE_W + NEXT_W;
  localparam int TDATA_W  = ((FIELDS_W + 7) / 8) * 8;
  localparam int PAD_W    = TDATA_W - FIELDS_W;

  // Null link: every bit set in the 17-bit signed successor field.
  localparam logic [NEXT_W-1:0] NULL_LINK = {NEXT_W{1'b1}};

  // Operation codes carried in the input tuser.
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_START = 2'd1;
  localparam logic [OP_W-1:0] OP_STEP  = 2'd2;

  // List codes carried in the output tuser.
  localparam logic LIST_KEPT    = 1'b0;
  localparam logic LIST_REMOVED = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_NODE,
    ST_SEEN,
    ST_EMIT,
    ST_TAIL_K
  } state_t;

endpackage

@@ rtl/core/linked_list_dedup_by_abs_key_core.sv @@
// Top level of the linked list deduplication core (deduplication by absolute key).
//
//  channel | direction | tdata (low bit up)                    | tuser     | tlast
//  --------+-----------+---------------------------------------+-----------+----------
//  s_*     | in        | node_addr, node_value, next_addr, pad | op        | -
//  m_*     | out       | out_addr, out_value, out_next, pad    | list_id   | walk_done
//
// A load transaction writes the node table straight from the idle state. A start
// transaction is followed by a clearing pass over all KEY_RANGE entries of the
// seen-key bitmap, during which s_tready is low. A step runs a node read and a bitmap
// read and, when it emits a relinked node, a value read of the previous node, then
// the output load. A step at the end of the walk emits one or two tails, kept tail
// first. Reset clears the control state only; the memories keep their contents. A
// stalled output holds the core in its emit or kept-tail state, but an input is
// taken as soon as the pending result sits in the output register.
module linked_list_dedup_by_abs_key_core
  import lldedup_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [TDATA_W-1:0] s_tdata,   // node_addr[15:0], node_value[31:16], next_addr[48:32]
  input  logic [OP_W-1:0]    s_tuser,   // op
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,   // out_addr[15:0], out_value[31:16], out_next[48:32]
  output logic               m_tuser,   // list_id
  output logic               m_tlast    // walk_done
);

  // Input fields.
  logic [ADDR_W-1:0]  in_addr;
  logic [VALUE_W-1:0] in_value;
  logic [NEXT_W-1:0]  in_next;
  logic               in_fire;

  assign in_addr  = s_tdata[ADDR_W-1:0];
  assign in_value = s_tdata[ADDR_W+VALUE_W-1:ADDR_W];
  assign in_next  = s_tdata[FIELDS_W-1:ADDR_W+VALUE_W];
  assign in_fire  = s_tvalid && s_tready;

  // Control state.
  state_t state, state_next;
  logic [NEXT_W-1:0] cursor, cursor_next;
  logic [NEXT_W-1:0] last_kept, last_kept_next;
  logic [NEXT_W-1:0] last_removed, last_removed_next;
  logic [KEY_AW-1:0] clr_idx, clr_idx_next;

  // Pending emission: everything but the value, which comes from the node memory.
  logic              em_load;
  logic              em_list, em_list_next;
  logic [ADDR_W-1:0] em_addr, em_addr_next;
  logic [NEXT_W-1:0] em_next, em_next_next;
  logic              em_done, em_done_next;

  // Output register.
  logic               out_load;
  logic               out_free;
  logic               out_list;
  logic [ADDR_W-1:0]  out_addr;
  logic [VALUE_W-1:0] out_value;
  logic [NEXT_W-1:0]  out_next;
  logic               out_done;

  // Node table: value and successor per node, one read and one write port.
  logic [VALUE_W-1:0] value_mem [NODE_COUNT];
  logic [NEXT_W-1:0]  next_mem  [NODE_COUNT];
  logic               node_we;
  logic               node_re;
  logic [NODE_AW-1:0] node_raddr;
  logic [VALUE_W-1:0] rd_value;
  logic [NEXT_W-1:0]  rd_next;

  // Seen-key bitmap.
  logic               seen_mem [KEY_RANGE];
  logic               seen_we;
  logic [KEY_AW-1:0]  seen_waddr;
  logic               seen_wdata;
  logic               seen_re;
  logic               rd_seen;

  // Key of the node just read: absolute value as a 16-bit unsigned number.
  logic [VALUE_W-1:0] key;
  logic [KEY_AW-1:0]  kidx;
  logic               is_new;
  logic [NEXT_W-1:0]  prev;
  logic               prev_valid;

  assign key        = rd_value[VALUE_W-1] ? (VALUE_W'(0) - rd_value) : rd_value;
  assign kidx       = key[KEY_AW-1:0];
  assign is_new     = !rd_seen;
  assign prev       = is_new ? last_kept : last_removed;
  assign prev_valid = !prev[NEXT_W-1];

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);
  assign node_we  = in_fire && (s_tuser == OP_LOAD);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          case (s_tuser)
            OP_START: state_next = ST_CLEAR;
            OP_STEP: begin
              if (!cursor[NEXT_W-1]) begin
                state_next = ST_NODE;
              end else if (!last_kept[NEXT_W-1]) begin
                state_next = ST_TAIL_K;
              end else if (!last_removed[NEXT_W-1]) begin
                state_next = ST_EMIT;
              end
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR: begin
        if (clr_idx == {KEY_AW{1'b1}}) begin
          state_next = ST_IDLE;
        end
      end
      ST_NODE: state_next = ST_SEEN;
      ST_SEEN: state_next = prev_valid ? ST_EMIT : ST_IDLE;
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_TAIL_K: begin
        if (out_free) begin
          state_next = last_removed[NEXT_W-1] ? ST_IDLE : ST_EMIT;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath control.
  always_comb begin
    cursor_next       = cursor;
    last_kept_next    = last_kept;
    last_removed_next = last_removed;
    clr_idx_next      = clr_idx;
    node_re           = 1'b0;
    node_raddr        = cursor[NODE_AW-1:0];
    seen_re           = 1'b0;
    seen_we           = 1'b0;
    seen_waddr        = kidx;
    seen_wdata        = 1'b1;
    em_load           = 1'b0;
    em_list_next      = LIST_KEPT;
    em_addr_next      = last_kept[ADDR_W-1:0];
    em_next_next      = NULL_LINK;
    em_done_next      = 1'b0;
    out_load          = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          case (s_tuser)
            OP_START: begin
              cursor_next       = {1'b0, in_addr};
              last_kept_next    = NULL_LINK;
              last_removed_next = NULL_LINK;
              clr_idx_next      = '0;
            end
            OP_STEP: begin
              if (!cursor[NEXT_W-1]) begin
                node_re = 1'b1;
              end else if (!last_kept[NEXT_W-1]) begin
                // End of walk: kept tail first; it closes the walk when nothing was removed.
                node_re        = 1'b1;
                node_raddr     = last_kept[NODE_AW-1:0];
                em_load        = 1'b1;
                em_list_next   = LIST_KEPT;
                em_addr_next   = last_kept[ADDR_W-1:0];
                em_done_next   = last_removed[NEXT_W-1];
                last_kept_next = NULL_LINK;
              end else if (!last_removed[NEXT_W-1]) begin
                node_re           = 1'b1;
                node_raddr        = last_removed[NODE_AW-1:0];
                em_load           = 1'b1;
                em_list_next      = LIST_REMOVED;
                em_addr_next      = last_removed[ADDR_W-1:0];
                em_done_next      = 1'b1;
                last_removed_next = NULL_LINK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_CLEAR: begin
        seen_we      = 1'b1;
        seen_waddr   = clr_idx;
        seen_wdata   = 1'b0;
        clr_idx_next = clr_idx + KEY_AW'(1);
      end
      ST_NODE: begin
        seen_re = 1'b1;
      end
      ST_SEEN: begin
        // Mark a new key, relink the previous node of the chosen list to this node.
        seen_we      = is_new;
        node_re      = prev_valid;
        node_raddr   = prev[NODE_AW-1:0];
        em_load      = 1'b1;
        em_list_next = is_new ? LIST_KEPT : LIST_REMOVED;
        em_addr_next = prev[ADDR_W-1:0];
        em_next_next = cursor;
        em_done_next = 1'b0;
        if (is_new) begin
          last_kept_next = cursor;
        end else begin
          last_removed_next = cursor;
        end
        // Any negative successor ends the walk.
        cursor_next = rd_next;
      end
      ST_EMIT: begin
        out_load = out_free;
      end
      ST_TAIL_K: begin
        if (out_free) begin
          out_load = 1'b1;
          if (!last_removed[NEXT_W-1]) begin
            node_re           = 1'b1;
            node_raddr        = last_removed[NODE_AW-1:0];
            em_load           = 1'b1;
            em_list_next      = LIST_REMOVED;
            em_addr_next      = last_removed[ADDR_W-1:0];
            em_done_next      = 1'b1;
            last_removed_next = NULL_LINK;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cursor       <= NULL_LINK;
      last_kept    <= NULL_LINK;
      last_removed <= NULL_LINK;
      clr_idx      <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      state        <= state_next;
      cursor       <= cursor_next;
      last_kept    <= last_kept_next;
      last_removed <= last_removed_next;
      clr_idx      <= clr_idx_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (em_load) begin
      em_list <= em_list_next;
      em_addr <= em_addr_next;
      em_next <= em_next_next;
      em_done <= em_done_next;
    end
    if (out_load) begin
      out_list  <= em_list;
      out_addr  <= em_addr;
      out_value <= rd_value;
      out_next  <= em_next;
      out_done  <= em_done;
    end
  end

  // Node table memory.
  always_ff @(posedge clk) begin
    if (node_we) begin
      value_mem[in_addr[NODE_AW-1:0]] <= in_value;
      next_mem[in_addr[NODE_AW-1:0]]  <= in_next;
    end
    if (node_re) begin
      rd_value <= value_mem[node_raddr];
      rd_next  <= next_mem[node_raddr];
    end
  end

  // Seen-key bitmap memory.
  always_ff @(posedge clk) begin
    if (seen_we) begin
      seen_mem[seen_waddr] <= seen_wdata;
    end
    if (seen_re) begin
      rd_seen <= seen_mem[kidx];
    end
  end

  assign m_tdata = {{PAD_W{1'b0}}, out_next, out_value, out_addr};
  assign m_tuser = out_list;
  assign m_tlast = out_done;

endmodule

@@ rtl/core/lldedup_checker.sv @@
// Port-level checks of the linked list deduplication core, bound to its top level.
module lldedup_checker
  import lldedup_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               s_tvalid,
  input logic               s_tready,
  input logic [OP_W-1:0]    s_tuser,
  input logic               m_tvalid,
  input logic               m_tready,
  input logic [TDATA_W-1:0] m_tdata,
  input logic               m_tuser,
  input logic               m_tlast
);

  // A stalled result holds its value.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled result changed");

  // A start transaction is followed by the bitmap clearing pass.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == OP_START) |=> !s_tready)
    else $error("input taken during the clearing pass");

  // A load transaction leaves the core ready again in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == OP_LOAD) |=> s_tready)
    else $error("load did not complete in one cycle");

  // The last result of a walk is a tail.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[FIELDS_W-1:ADDR_W+VALUE_W] == NULL_LINK)
    else $error("walk end result is not a tail");

  // A new result only comes out of a busy cycle.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result appeared straight from idle");

endmodule

bind linked_list_dedup_by_abs_key_core lldedup_checker u_lldedup_checker (.*);

@@ dv/tb.sv @@
// Self-checking testbench for the linked list deduplication core.
`timescale 1ns / 100ps

module tb;
  import lldedup_pkg::*;

  // The unused operation code; the core must ignore it.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  // The random part starts no new walk once this many input transactions have been sent.
  localparam int ITEM_TARGET = 1450;

  // One relinked node or tail as it leaves the core, fields in output order.
  typedef struct packed {
    logic               list_id;
    logic [ADDR_W-1:0]  addr;
    logic [VALUE_W-1:0] value;
    logic [NEXT_W-1:0]  link;
    logic               done;
  } link_t;

  // Tracks the node table, the seen-key bitmap and both list ends, and holds
  // the relinked nodes that the core still owes, oldest first.
  class relink_tracker;
    logic [VALUE_W-1:0] node_value_mem [int];
    logic [NEXT_W-1:0]  node_link_mem [int];
    bit                 seen_key [int];
    int                 cursor;
    int                 last_kept;
    int                 last_removed;
    link_t              pending_links [$];
    int                 mismatches;
    int                 links_checked;

    function new();
      cursor        = -1;
      last_kept     = -1;
      last_removed  = -1;
      mismatches    = 0;
      links_checked = 0;
    endfunction

    // The emitted value is read from the table when the result is queued.
    function void queue_link(logic id, int addr, logic [NEXT_W-1:0] link, logic done);
      link_t r;
      r.list_id = id;
      r.addr    = ADDR_W'(addr);
      r.value   = node_value_mem[addr];
      r.link    = link;
      r.done    = done;
      pending_links.insert(pending_links.size(), r);
    endfunction

    // Updates the state for one accepted input transaction and queues the
    // results that it causes.
    function void predict_links(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
                                logic [VALUE_W-1:0] value, logic [NEXT_W-1:0] link);
      logic [VALUE_W-1:0] raw;
      logic [VALUE_W-1:0] mag;
      logic [NEXT_W-1:0]  nx;
      int                 kidx;
      case (op)
        OP_LOAD: begin
          node_value_mem[addr] = value;
          node_link_mem[addr]  = link;
        end
        OP_START: begin
          seen_key.delete();
          cursor       = int'(addr);
          last_kept    = -1;
          last_removed = -1;
        end
        OP_STEP: begin
          if (cursor < 0) begin
            // End of the walk: flush the tail of each non-empty list.
            if (last_kept >= 0)
              queue_link(LIST_KEPT, last_kept, NULL_LINK, last_removed < 0);
            if (last_removed >= 0)
              queue_link(LIST_REMOVED, last_removed, NULL_LINK, 1'b1);
            last_kept    = -1;
            last_removed = -1;
          end else begin
            raw  = node_value_mem[cursor];
            mag  = raw[VALUE_W-1] ? -raw : raw;
            kidx = int'(mag) % KEY_RANGE;
            nx   = node_link_mem[cursor];
            if (!seen_key.exists(kidx)) begin
              seen_key[kidx] = 1'b1;
              if (last_kept >= 0)
                queue_link(LIST_KEPT, last_kept, NEXT_W'(cursor), 1'b0);
              last_kept = cursor;
            end else begin
              if (last_removed >= 0)
                queue_link(LIST_REMOVED, last_removed, NEXT_W'(cursor), 1'b0);
              last_removed = cursor;
            end
            // Any negative successor ends the walk.
            cursor = nx[NEXT_W-1] ? -1 : int'(nx[ADDR_W-1:0]);
          end
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [NEXT_W-1:0] exp,
                                logic [NEXT_W-1:0] got);
      if (got !== exp) begin
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp, got);
        mismatches++;
      end
    endfunction

    function void check_link(link_t got);
      link_t exp;
      if (pending_links.size() == 0) begin
        $display("%0t: unexpected result, expected none, got list %0d addr %h",
                 $time, got.list_id, got.addr);
        mismatches++;
        return;
      end
      exp = pending_links.pop_front();
      links_checked++;
      compare_field("list_id", NEXT_W'(exp.list_id), NEXT_W'(got.list_id));
      compare_field("out_addr", NEXT_W'(exp.addr), NEXT_W'(got.addr));
      compare_field("out_value", NEXT_W'(exp.value), NEXT_W'(got.value));
      compare_field("out_next", exp.link, got.link);
      compare_field("walk_done", NEXT_W'(exp.done), NEXT_W'(got.done));
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               s_tvalid;
  logic               s_tready;
  logic [TDATA_W-1:0] s_tdata;
  logic [OP_W-1:0]    s_tuser;
  logic               m_tvalid;
  logic               m_tready;
  logic [TDATA_W-1:0] m_tdata;
  logic               m_tuser;
  logic               m_tlast;

  relink_tracker tracker = new();
  link_t         got_link;

  // Stimulus bookkeeping: every address ever loaded. Links only ever point at
  // loaded addresses or are negative, so a walk never reads an unwritten node.
  int loaded_addrs [$];
  bit is_loaded [int];
  bit sender_calm;
  int items_sent;
  int walks_started;

  linked_list_dedup_by_abs_key_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Node values: mostly small magnitudes with random sign so that keys repeat,
  // plus full-range values and the extremes of the field.
  function automatic logic [VALUE_W-1:0] pick_value(int kspan);
    int                 r;
    logic [VALUE_W-1:0] mag;
    r = $urandom_range(0, 19);
    if (r == 0) return VALUE_W'($urandom);
    if (r == 1) begin
      case ($urandom_range(0, 3))
        0:       return 16'h7FFF;
        1:       return 16'h8001;
        2:       return 16'h8000;
        default: return 16'h0000;
      endcase
    end
    mag = VALUE_W'($urandom_range(0, kspan));
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  // A successor that keeps every walk on loaded nodes: null, some other
  // negative value, or a loaded address (which may close a loop).
  function automatic logic [NEXT_W-1:0] safe_link();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6 || loaded_addrs.size() == 0) return NULL_LINK;
    if (r < 8) return {1'b1, 16'($urandom)};
    return {1'b0, 16'(loaded_addrs[$urandom_range(0, loaded_addrs.size() - 1)])};
  endfunction

  // Drives one input transaction at the falling edge and holds it until the
  // core takes it. The caller's previous transaction was taken at the last
  // rising edge, so tvalid either stays high for this one or drops for a gap.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                           input logic [VALUE_W-1:0] value,
                           input logic [NEXT_W-1:0] link);
    int gap;
    gap = pick_gap(sender_calm);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = op;
    s_tdata  = {{PAD_W{1'b0}}, link, value, addr};
    do @(posedge clk); while (!s_tready);
    tracker.predict_links(op, addr, value, link);
    items_sent++;
    if (op == OP_START) walks_started++;
    if (op == OP_LOAD && !is_loaded.exists(int'(addr))) begin
      is_loaded[int'(addr)] = 1'b1;
      loaded_addrs.insert(loaded_addrs.size(), int'(addr));
    end
  endtask

  // Holds the sender off until every owed result has left the core, then waits on
  // in case a step that emits nothing is still running.
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (tracker.pending_links.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // One random walk: build a list from its tail up, start at its head, then
  // mostly steps with noise, loads and fresh nodes mixed in. Some walks loop
  // and never end; the next start cuts them off.
  task automatic run_walk();
    int                len;
    int                kspan;
    int                steps;
    int                r;
    logic [ADDR_W-1:0] head;
    logic [NEXT_W-1:0] link;
    len         = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : $urandom_range(16, 50);
    kspan       = $urandom_range(1, len);
    sender_calm = ($urandom_range(0, 4) == 0);
    link        = safe_link();
    for (int i = 0; i < len; i++) begin
      head = ADDR_W'($urandom);
      send_item(OP_LOAD, head, pick_value(kspan), link);
      link = {1'b0, head};
    end
    if (walks_started % 4 == 0) wait_drained();
    send_item(OP_START, head, VALUE_W'($urandom), NEXT_W'($urandom));
    steps = len + $urandom_range(0, 4);
    for (int i = 0; i < steps; i++) begin
      r = $urandom_range(0, 19);
      if (r == 0)
        send_item(OP_UNUSED, ADDR_W'($urandom), VALUE_W'($urandom), NEXT_W'($urandom));
      else if (r == 1)
        send_item(OP_LOAD, ADDR_W'(loaded_addrs[$urandom_range(0, loaded_addrs.size() - 1)]),
                  pick_value(kspan), safe_link());
      else if (r == 2)
        send_item(OP_LOAD, ADDR_W'($urandom), pick_value(kspan), safe_link());
      else
        send_item(OP_STEP, ADDR_W'($urandom), VALUE_W'($urandom), NEXT_W'($urandom));
    end
  endtask

  // The receiver alternates ready bursts with stalls; a few bursts are long
  // so that stretches run with no backpressure at all.
  initial begin
    int burst;
    int gap;
    m_tready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      m_tready = 1'b1;
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 8);
      repeat (burst) @(negedge clk);
      gap = pick_gap(1'b0);
      if (gap > 0) begin
        m_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  // Every output transaction is checked against the oldest owed result.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_link = {m_tuser, m_tdata[ADDR_W-1:0], m_tdata[ADDR_W+VALUE_W-1:ADDR_W],
                  m_tdata[FIELDS_W-1:ADDR_W+VALUE_W], m_tlast};
      tracker.check_link(got_link);
    end
  end

  initial begin
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tuser       = OP_LOAD;
    sender_calm   = 1'b0;
    items_sent    = 0;
    walks_started = 0;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // A step before any start and an unused op both produce nothing.
    send_item(OP_STEP, 16'h0000, 16'h0000, 17'h00000);
    send_item(OP_UNUSED, 16'hFFFF, 16'hFFFF, 17'h1FFFF);

    // A six-node list over the address and value extremes, built tail first.
    // Keys: 32767 new, 32767 again, 0 new, -32768 folds onto index 0 and is a
    // duplicate, 7 new, -7 duplicate. The tail ends on a negative link other
    // than -1.
    send_item(OP_LOAD, 16'h8001, 16'hFFF9, 17'h10005);
    send_item(OP_LOAD, 16'h1234, 16'h0007, 17'h08001);
    send_item(OP_LOAD, 16'hAAAA, 16'h8000, 17'h01234);
    send_item(OP_LOAD, 16'h5555, 16'h0000, 17'h0AAAA);
    send_item(OP_LOAD, 16'hFFFF, 16'h8001, 17'h05555);
    send_item(OP_LOAD, 16'h0000, 16'h7FFF, 17'h0FFFF);
    send_item(OP_START, 16'h0000, 16'hFFFF, 17'h1FFFF);
    // First node of each list: nothing to relink yet.
    send_item(OP_STEP, 16'hFFFF, 16'hFFFF, 17'h1FFFF);
    send_item(OP_STEP, 16'h0000, 16'h0000, 17'h00000);
    // A load mid-walk rewrites the pending kept node; its new value must show.
    send_item(OP_LOAD, 16'h0000, 16'h0064, 17'h1FFFF);
    send_item(OP_STEP, 16'h0000, 16'h0000, 17'h00000);
    send_item(OP_STEP, 16'h0000, 16'h0000, 17'h00000);
    send_item(OP_STEP, 16'h0000, 16'h0000, 17'h00000);
    send_item(OP_STEP, 16'h0000, 16'h0000, 17'h00000);
    // Both tails, then a step after the walk that produces nothing.
    send_item(OP_STEP, 16'h0000, 16'h0000, 17'h00000);
    send_item(OP_STEP, 16'h0000, 16'h0000, 17'h00000);
    wait_drained();

    // A single-node walk: only the kept tail comes out, flagged as the last.
    send_item(OP_LOAD, 16'h00F0, 16'h0003, 17'h1FFFF);
    send_item(OP_START, 16'h00F0, 16'h0000, 17'h00000);
    send_item(OP_STEP, 16'h0000, 16'h0000, 17'h00000);
    send_item(OP_STEP, 16'h0000, 16'h0000, 17'h00000);

    while (items_sent < ITEM_TARGET) run_walk();
    wait_drained();

    $display("Sent %0d input transactions across %0d walks of random lists with loads,",
             items_sent, walks_started);
    $display("unused ops and restarts mixed in; %0d relinked nodes and tails were checked.",
             tracker.links_checked);
    if (tracker.mismatches == 0 && tracker.pending_links.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // Each start costs a full clearing pass of the key bitmap, which dominates the run
  // time; this timeout lies well beyond the expected run.
  initial begin
    #60000000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
